/* rtl/fqr_pkg.sv */
// Package for the FIFO queue with remove-by-value.
// Holds the request and response item types, operation codes and state encoding.
// No dependencies.
`default_nettype none

package fqr_pkg;

	typedef enum logic [1:0] {
		KIND_PUSH   = 2'd0,
		KIND_POP    = 2'd1,
		KIND_PEEK   = 2'd2,
		KIND_REMOVE = 2'd3
	} fqr_kind_t;

	typedef struct packed {
		fqr_kind_t   kind;
		logic [31:0] item_value;
	} fqr_req_t;

	typedef struct packed {
		logic [31:0] out_value;
		logic        out_valid;
		logic [4:0]  occupancy;
		logic        push_dropped;
		logic [4:0]  removed_count;
	} fqr_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} fqr_state_t;

endpackage

`default_nettype wire

/* rtl/fifo_queue_with_remove.sv */
// FIFO queue of handles with push, pop, peek and remove-all-equal.
// Push, pop and peek go through the result state, where the result is registered. A new item is accepted
// once the result is registered, so the queue takes no new item before the last one is answered.
// Remove registers its result after a scan state that visits each entry: it walks the entries
// through the store's single read port, one per cycle, and writes survivors back compacted
// through its write port. A remove on an empty queue skips the scan and goes straight to the
// result state like the other kinds.
// A result held by rsp_stall keeps the next result waiting and stalls the input after that.
// Reset clears head, count and handshake state; the entry store is not cleared.
`default_nettype none

module fifo_queue_with_remove
	import fqr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ITEM_WIDTH  = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire fqr_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output fqr_rsp_t      rsp
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// Offsets never exceed the depth, so one conditional subtract wraps the sum.
	function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW + 1)'(base) + (CW + 1)'(off);
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[IW-1:0];
	endfunction

	fqr_state_t state_q, state_d;

	logic [IW-1:0]         head_q;
	logic [CW-1:0]         cnt_q;
	logic [ITEM_WIDTH-1:0] item_q;
	logic                  pend_read_q;
	logic                  pend_drop_q;
	logic [CW-1:0]         scan_q;
	logic [CW-1:0]         kept_q;
	logic [CW-1:0]         removed_q;
	logic                  rsp_valid_q;
	fqr_rsp_t              rsp_q;

	logic [ITEM_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [ITEM_WIDTH-1:0] rd_data_q;

	logic                  req_accept;
	logic                  rsp_free;
	logic                  rsp_load;
	logic                  full;
	logic [ITEM_WIDTH+31:0] req_wide;
	logic [ITEM_WIDTH-1:0] req_item;
	logic                  entry_match;
	logic                  scan_last;
	logic [CW-1:0]         kept_next;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [ITEM_WIDTH-1:0] wr_data;
	logic [ITEM_WIDTH+31:0] out_wide;
	logic [CW+4:0]         cnt_wide;
	logic [CW+4:0]         removed_wide;

	assign req_accept  = req_valid && !req_stall;
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign full        = (cnt_q == DEPTH_C);
	assign req_wide    = {{ITEM_WIDTH{1'b0}}, req.item_value};
	assign req_item    = req_wide[ITEM_WIDTH-1:0];
	assign entry_match = (rd_data_q == item_q);
	assign scan_last   = (scan_q == cnt_q - CW'(1));
	assign kept_next   = entry_match ? kept_q : kept_q + CW'(1);
	assign out_wide    = {32'd0, rd_data_q};
	assign cnt_wide    = {5'd0, cnt_q};
	assign removed_wide = {5'd0, removed_q};

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					if (req.kind == KIND_REMOVE && cnt_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = wrap_add(head_q, cnt_q);
		wr_data   = req_item;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				rd_en     = req_accept;
				wr_en     = req_accept && req.kind == KIND_PUSH && !full;
			end
			ST_SCAN: begin
				// Read the next entry while the current one is compared and written back.
				rd_en   = 1'b1;
				rd_addr = wrap_add(head_q, scan_q + CW'(1));
				wr_en   = !entry_match;
				wr_addr = wrap_add(head_q, kept_q);
				wr_data = rd_data_q;
			end
			ST_RESP: begin
				rsp_load = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						if (req.kind == KIND_PUSH && !full) begin
							cnt_q <= cnt_q + CW'(1);
						end else if (req.kind == KIND_POP && cnt_q != '0) begin
							head_q <= wrap_add(head_q, CW'(1));
							cnt_q  <= cnt_q - CW'(1);
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						cnt_q <= kept_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					item_q      <= req_item;
					pend_read_q <= (req.kind == KIND_POP || req.kind == KIND_PEEK)
						&& cnt_q != '0;
					pend_drop_q <= req.kind == KIND_PUSH && full;
					scan_q      <= '0;
					kept_q      <= '0;
					removed_q   <= '0;
				end
			end
			ST_SCAN: begin
				scan_q <= scan_q + CW'(1);
				kept_q <= kept_next;
				if (entry_match) begin
					removed_q <= removed_q + CW'(1);
				end
			end
			default: begin
			end
		endcase

		if (rsp_load) begin
			rsp_q.out_value     <= pend_read_q ? out_wide[31:0] : 32'd0;
			rsp_q.out_valid     <= pend_read_q;
			rsp_q.occupancy     <= cnt_wide[4:0];
			rsp_q.push_dropped  <= pend_drop_q;
			rsp_q.removed_count <= removed_wide[4:0];
		end
	end

	// Entry store: one write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* dv/fifo_queue_with_remove_test.sv */
// Self-checking testbench for fifo_queue_with_remove: directed and random push, pop,
// peek and remove items with random idling on both channels, checked against a queue model.
// Depends on fqr_pkg and the fifo_queue_with_remove RTL.
`timescale 1ns / 100ps

module fifo_queue_with_remove_test;
	import fqr_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 1200;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		fqr_req_t req;
		bit       wait_drain;
	} backlog_entry_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	fqr_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	fqr_rsp_t rsp;

	backlog_entry_t req_backlog[$];
	fqr_rsp_t       awaited_rsps[$];
	int             stim_total;
	int             sent_count;
	int             checked_count;
	int             mismatch_count;

	// Queue model state.
	logic [31:0] model_store[DEPTH];
	logic [3:0]  model_head;
	logic [4:0]  model_count;

	fifo_queue_with_remove i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the queue model and returns the answer it should give.
	function automatic fqr_rsp_t apply_to_model(input fqr_req_t r);
		logic [31:0] kept[DEPTH];
		int          nkept;
		logic [3:0]  idx;
		fqr_rsp_t    a;
		a = '0;
		nkept = 0;
		case (r.kind)
			KIND_PUSH: begin
				if (model_count == 5'(DEPTH)) begin
					a.push_dropped = 1'b1;
				end else begin
					model_store[model_head + model_count[3:0]] = r.item_value;
					model_count = model_count + 5'd1;
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (model_count != 5'd0) begin
					a.out_value = model_store[model_head];
					a.out_valid = 1'b1;
					if (r.kind == KIND_POP) begin
						model_head = model_head + 4'd1;
						model_count = model_count - 5'd1;
					end
				end
			end
			default: begin
				for (int i = 0; i < model_count; i++) begin
					idx = model_head + 4'(i);
					if (model_store[idx] == r.item_value)
						a.removed_count = a.removed_count + 5'd1;
					else begin
						kept[nkept] = model_store[idx];
						nkept++;
					end
				end
				for (int i = 0; i < nkept; i++)
					model_store[model_head + 4'(i)] = kept[i];
				model_count = 5'(nkept);
			end
		endcase
		a.occupancy = model_count;
		return a;
	endfunction

	function automatic int idle_phase();
		if (sent_count < stim_total / 3)
			return 0;
		if (sent_count < 2 * stim_total / 3)
			return 1;
		return 2;
	endfunction

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Request driver and result-side stall.
	always @(posedge clk or negedge arst_n) begin
		bit sender_idle;
		bit hold;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			rsp_stall <= 1'b0;
			sent_count <= 0;
		end else begin
			case (idle_phase())
				0: begin
					sender_idle = roll(23);
					rsp_stall <= roll(82);
				end
				1: begin
					sender_idle = roll(82);
					rsp_stall <= roll(23);
				end
				default: begin
					sender_idle = 1'b0;
					rsp_stall <= 1'b0;
				end
			endcase
			if (req_valid && !req_stall)
				sent_count <= sent_count + 1;
			if (!req_valid || !req_stall) begin
				// A drain item waits until every earlier item has been answered.
				hold = req_backlog.size() != 0 && req_backlog[0].wait_drain &&
					!(sent_count == checked_count && !(req_valid && !req_stall));
				if (req_backlog.size() != 0 && !sender_idle && !hold) begin
					req_valid <= 1'b1;
					req <= req_backlog.pop_front().req;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result monitor: answers are checked first, then accepted requests are predicted.
	always @(posedge clk or negedge arst_n) begin
		fqr_rsp_t want;
		if (!arst_n) begin
			checked_count <= 0;
			model_head = '0;
			model_count = '0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				checked_count <= checked_count + 1;
				if (awaited_rsps.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
					mismatch_count++;
				end else begin
					want = awaited_rsps.pop_front();
					check_field("out_value", want.out_value, rsp.out_value);
					check_field("out_valid", 32'(want.out_valid), 32'(rsp.out_valid));
					check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
					check_field("push_dropped", 32'(want.push_dropped),
						32'(rsp.push_dropped));
					check_field("removed_count", 32'(want.removed_count),
						32'(rsp.removed_count));
				end
			end
			if (req_valid && !req_stall)
				awaited_rsps.push_back(apply_to_model(req));
		end
	end

	task automatic add_req(input fqr_kind_t kind, input logic [31:0] value,
			input bit wait_drain);
		backlog_entry_t e;
		e.req.kind = kind;
		e.req.item_value = value;
		e.wait_drain = wait_drain;
		req_backlog.push_back(e);
	endtask

	function automatic logic [31:0] pick_handle();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [31:0] pool[4];
		int          generated;
		int          seg_len;
		int          push_pct;
		fqr_kind_t   kind;
		logic [31:0] value;

		// Empty queue: pop, peek and remove all answer with nothing.
		add_req(KIND_POP, 32'hFFFF_FFFF, 1'b0);
		add_req(KIND_PEEK, 32'h0000_0000, 1'b0);
		add_req(KIND_REMOVE, 32'h0000_0000, 1'b0);
		add_req(KIND_PUSH, 32'hFFFF_FFFF, 1'b0);
		add_req(KIND_PUSH, 32'h0000_0000, 1'b0);
		add_req(KIND_PUSH, 32'hFFFF_FFFF, 1'b0);
		add_req(KIND_PEEK, 32'h1234_5678, 1'b0);
		add_req(KIND_REMOVE, 32'hFFFF_FFFF, 1'b0);
		add_req(KIND_REMOVE, 32'h0000_0007, 1'b0);
		add_req(KIND_POP, 32'h0000_0000, 1'b0);
		// Fill past the top from a moved head, then empty the queue by two removes.
		for (int i = 0; i < DEPTH; i++)
			add_req(KIND_PUSH, (i % 2) ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A, 1'b0);
		add_req(KIND_PUSH, 32'hDEAD_0001, 1'b0);
		add_req(KIND_REMOVE, 32'h5A5A_5A5A, 1'b0);
		add_req(KIND_REMOVE, 32'hA5A5_A5A5, 1'b0);

		// Random segments with a varying push bias and a small pool of handles,
		// so that removes often match several entries.
		generated = 0;
		while (generated < RANDOM_ITEMS) begin
			seg_len = $urandom_range(60, 10);
			push_pct = $urandom_range(80, 20);
			for (int p = 0; p < 4; p++)
				pool[p] = pick_handle();
			for (int j = 0; j < seg_len; j++) begin
				if (roll(push_pct))
					kind = KIND_PUSH;
				else begin
					case ($urandom_range(2))
						0: kind = KIND_POP;
						1: kind = KIND_PEEK;
						default: kind = KIND_REMOVE;
					endcase
				end
				value = roll(70) ? pool[$urandom_range(3)] : $urandom();
				add_req(kind, value, generated == 0 || $urandom_range(149) == 0);
				generated++;
			end
		end
		stim_total = req_backlog.size();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (req_backlog.size() != 0 || req_valid || checked_count != sent_count)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (awaited_rsps.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				awaited_rsps.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("%0t: timeout", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
